// ----- hw/rtl/gss_pkg.sv -----
// shared types, codes and helpers for the gimbal sweep calibration sequencer
package gss_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PAUSE_W    = 11;
    localparam int DIV_W      = 16;
    localparam int SLOT_W     = 10;

    localparam logic [PAUSE_W-1:0] PAUSE_LEN = 11'd2000;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // phase codes
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_INIT = 3'd1;
    localparam logic [2:0] PH_TOP  = 3'd2;
    localparam logic [2:0] PH_PTOP = 3'd3;
    localparam logic [2:0] PH_DOWN = 3'd4;
    localparam logic [2:0] PH_PBOT = 3'd5;
    localparam logic [2:0] PH_UP   = 3'd6;
    localparam logic [2:0] PH_DONE = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOP_IMU_ANGLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_IMU_ANGLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_SPEED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PER_TICK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P           = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D           = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_DIVIDER   = 3'd6;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] enc_angle;
        logic signed [31:0] enc_speed;
        logic signed [31:0] imu_angle;
    } item_t;

    typedef struct packed {
        logic signed [31:0] torque;
        logic [2:0]         phase;
        logic               record_valid;
        logic [SLOT_W-1:0]  record_slot;
        logic signed [31:0] record_enc;
        logic signed [31:0] record_imu;
    } result_t;

    // clamp a wide signed value into 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic same;
        same = (&x[65:31]) || !(|x[65:31]);
        if (same)
            sat32 = x[31:0];
        else if (x[65])
            sat32 = 32'sh8000_0000;
        else
            sat32 = 32'sh7FFF_FFFF;
    endfunction

endpackage

// ----- hw/rtl/gimbal_sweep_calibration_sequencer.sv -----
// gimbal sweep calibration sequencer: phase sequencer, pd torque law and record tagging
//
//  channel  | direction | handshake                  | payload
//  item     | in        | item_valid / item_stall    | item   (item_t)
//  result   | out       | result_valid / result_stall| result (result_t)
//  cfg      | in        | cfg_write                  | cfg_index, cfg_data
//
// one item per cycle sustained while result_stall is low; a taken item is registered through the
// sequencer step, the two pd multiplies, then sum and clamp into the output register
// rst_n clears the pipeline valids, the sequencer state and the registers to their defaults
// a stalled result holds the output register; empty stages upstream keep taking items
// until the pipeline is full, then item_stall rises
module gimbal_sweep_calibration_sequencer
    import gss_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    // configuration
    logic signed [31:0] top_imu_angle_reg;
    logic signed [31:0] bottom_imu_angle_reg;
    logic [30:0]        sweep_speed_reg;
    logic [30:0]        step_per_tick_reg;
    logic signed [31:0] gain_p_reg;
    logic signed [31:0] gain_d_reg;
    logic [DIV_W-1:0]   record_divider_reg;

    // sequencer state
    logic [2:0]         phase_reg, phase_next;
    logic signed [31:0] target_angle_reg, target_angle_next;
    logic signed [31:0] target_speed_reg, target_speed_next;
    logic signed [31:0] upper_limit_reg, upper_limit_next;
    logic signed [31:0] lower_limit_reg, lower_limit_next;
    logic [PAUSE_W-1:0] pause_ticks_reg, pause_ticks_next;
    logic [DIV_W-1:0]   divider_count_reg, divider_count_next;
    logic [CNT_W-1:0]   record_count_reg, record_count_next;

    // pipeline
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    item_t              s1_item_reg;
    logic signed [31:0] s2_ep_reg, s2_ed_reg;
    logic signed [63:0] s3_prod_p_reg, s3_prod_d_reg;
    result_t            s2_meta_reg, s2_meta_next;
    result_t            s3_meta_reg;
    result_t            out_reg, out_next;

    logic go_out, go3, go2, go1;

    // stage loads when empty or when its successor loads
    assign go_out = !(out_valid_reg && result_stall);
    assign go3    = !s3_valid_reg || go_out;
    assign go2    = !s2_valid_reg || go3;
    assign go1    = !s1_valid_reg || go2;

    assign item_stall   = !go1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_imu_angle_reg    <= '0;
            bottom_imu_angle_reg <= '0;
            sweep_speed_reg      <= '0;
            step_per_tick_reg    <= '0;
            gain_p_reg           <= '0;
            gain_d_reg           <= '0;
            record_divider_reg   <= DIV_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TOP_IMU_ANGLE:    top_imu_angle_reg    <= cfg_data;
                REG_BOTTOM_IMU_ANGLE: bottom_imu_angle_reg <= cfg_data;
                REG_SWEEP_SPEED:      sweep_speed_reg      <= cfg_data[30:0];
                REG_STEP_PER_TICK:    step_per_tick_reg    <= cfg_data[30:0];
                REG_GAIN_P:           gain_p_reg           <= cfg_data;
                REG_GAIN_D:           gain_d_reg           <= cfg_data;
                REG_RECORD_DIVIDER:   record_divider_reg   <= cfg_data[DIV_W-1:0];
                default:              ;
            endcase
        end
    end

    // sequencer step for the item in the input register
    logic signed [31:0] enc, spd, imu;
    logic signed [31:0] step_up, step_dn, speed_pos, speed_neg, offset_dummy;
    logic signed [31:0] ep, ed;
    logic [PAUSE_W-1:0] pause_inc;
    logic [DIV_W-1:0]   div_inc;
    logic               rec;

    always_comb
    begin
        enc       = s1_item_reg.enc_angle;
        spd       = s1_item_reg.enc_speed;
        imu       = s1_item_reg.imu_angle;
        step_up   = sat32(66'(target_angle_reg) + 66'(signed'({1'b0, step_per_tick_reg})));
        step_dn   = sat32(66'(target_angle_reg) - 66'(signed'({1'b0, step_per_tick_reg})));
        speed_pos = signed'({1'b0, sweep_speed_reg});
        speed_neg = -speed_pos;
        offset_dummy = '0;
        pause_inc = pause_ticks_reg + PAUSE_W'(1);
        div_inc   = divider_count_reg + DIV_W'(1);

        phase_next         = phase_reg;
        target_angle_next  = target_angle_reg;
        target_speed_next  = target_speed_reg;
        upper_limit_next   = upper_limit_reg;
        lower_limit_next   = lower_limit_reg;
        pause_ticks_next   = pause_ticks_reg;
        divider_count_next = divider_count_reg;
        record_count_next  = record_count_reg;
        ep  = offset_dummy;
        ed  = offset_dummy;
        rec = 1'b0;

        case (s1_item_reg.cmd)
            CMD_START:
            begin
                if (phase_reg == PH_IDLE || phase_reg == PH_DONE)
                begin
                    phase_next        = PH_INIT;
                    record_count_next = '0;
                end
            end
            CMD_STOP:
                phase_next = PH_DONE;
            CMD_TICK:
            begin
                case (phase_reg)
                    PH_INIT:
                    begin
                        upper_limit_next  = sat32(66'(top_imu_angle_reg) + 66'(enc) - 66'(imu));
                        lower_limit_next  = sat32(66'(bottom_imu_angle_reg) + 66'(enc)
                                                  - 66'(imu));
                        target_angle_next = enc;
                        target_speed_next = '0;
                        phase_next        = PH_TOP;
                    end
                    PH_TOP:
                    begin
                        // approach the top limit from whichever side the target sits
                        if (target_angle_reg < upper_limit_reg)
                        begin
                            target_angle_next = step_up;
                            target_speed_next = speed_pos;
                            if (step_up >= upper_limit_reg)
                            begin
                                target_angle_next = upper_limit_reg;
                                pause_ticks_next  = '0;
                                phase_next        = PH_PTOP;
                            end
                        end
                        else
                        begin
                            target_angle_next = step_dn;
                            target_speed_next = speed_neg;
                            if (step_dn <= upper_limit_reg)
                            begin
                                target_angle_next = upper_limit_reg;
                                pause_ticks_next  = '0;
                                phase_next        = PH_PTOP;
                            end
                        end
                    end
                    PH_PTOP, PH_PBOT:
                    begin
                        target_speed_next = '0;
                        pause_ticks_next  = pause_inc;
                        if (pause_inc >= PAUSE_LEN)
                        begin
                            if (phase_reg == PH_PTOP)
                            begin
                                target_speed_next = speed_neg;
                                phase_next        = PH_DOWN;
                            end
                            else
                            begin
                                target_speed_next = speed_pos;
                                phase_next        = PH_UP;
                            end
                        end
                    end
                    PH_DOWN:
                    begin
                        target_speed_next = speed_neg;
                        target_angle_next = step_dn;
                        if (step_dn <= lower_limit_reg)
                        begin
                            target_angle_next = lower_limit_reg;
                            pause_ticks_next  = '0;
                            phase_next        = PH_PBOT;
                        end
                    end
                    PH_UP:
                    begin
                        target_speed_next = speed_pos;
                        target_angle_next = step_up;
                        if (step_up >= upper_limit_reg)
                        begin
                            target_angle_next = upper_limit_reg;
                            phase_next        = PH_DONE;
                        end
                    end
                    default:
                        target_speed_next = '0;
                endcase

                // pd errors use the phase after the transition; zero errors give zero torque
                if (phase_next != PH_IDLE && phase_next != PH_DONE)
                begin
                    ep = sat32(66'(target_angle_next) - 66'(enc));
                    ed = sat32(66'(target_speed_next) - 66'(spd));
                    if (phase_next == PH_DOWN || phase_next == PH_UP)
                    begin
                        divider_count_next = div_inc;
                        if (div_inc >= record_divider_reg)
                        begin
                            divider_count_next = '0;
                            if (record_count_reg < MAX_CNT)
                            begin
                                rec               = 1'b1;
                                record_count_next = record_count_reg + CNT_W'(1);
                            end
                        end
                    end
                end
            end
            default:
                ;
        endcase

        s2_meta_next.torque       = '0;
        s2_meta_next.phase        = phase_next;
        s2_meta_next.record_valid = rec;
        s2_meta_next.record_slot  = rec ? SLOT_W'(record_count_reg) : '0;
        s2_meta_next.record_enc   = rec ? enc : '0;
        s2_meta_next.record_imu   = rec ? imu : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            target_angle_reg  <= '0;
            target_speed_reg  <= '0;
            upper_limit_reg   <= '0;
            lower_limit_reg   <= '0;
            pause_ticks_reg   <= '0;
            divider_count_reg <= '0;
            record_count_reg  <= '0;
        end
        else if (go2 && s1_valid_reg)
        begin
            phase_reg         <= phase_next;
            target_angle_reg  <= target_angle_next;
            target_speed_reg  <= target_speed_next;
            upper_limit_reg   <= upper_limit_next;
            lower_limit_reg   <= lower_limit_next;
            pause_ticks_reg   <= pause_ticks_next;
            divider_count_reg <= divider_count_next;
            record_count_reg  <= record_count_next;
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (go1)
                s1_valid_reg <= item_valid;
            if (go2)
                s2_valid_reg <= s1_valid_reg;
            if (go3)
                s3_valid_reg <= s2_valid_reg;
            if (go_out)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // arithmetic shift of the exact products floors each pd term
    always_comb
    begin
        out_next        = s3_meta_reg;
        out_next.torque = sat32(66'(s3_prod_p_reg >>> FRAC_BITS)
                                + 66'(s3_prod_d_reg >>> FRAC_BITS));
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (go1)
            s1_item_reg <= item;
        if (go2)
        begin
            s2_ep_reg   <= ep;
            s2_ed_reg   <= ed;
            s2_meta_reg <= s2_meta_next;
        end
        if (go3)
        begin
            s3_prod_p_reg <= 64'(s2_ep_reg) * 64'(gain_p_reg);
            s3_prod_d_reg <= 64'(s2_ed_reg) * 64'(gain_d_reg);
            s3_meta_reg   <= s2_meta_reg;
        end
        if (go_out)
            out_reg <= out_next;
    end

    // checks
    a_torque_zero_when_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.phase == PH_IDLE || out_reg.phase == PH_DONE)
            |-> out_reg.torque == '0)
        else $error("torque not zero in idle or done");

    a_record_only_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.record_valid
            |-> (out_reg.phase == PH_DOWN || out_reg.phase == PH_UP))
        else $error("record outside a sweep phase");

    a_record_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        record_count_reg <= MAX_CNT)
        else $error("record count beyond limit");

    a_state_holds_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(go2 && s1_valid_reg) |=> $stable(phase_reg) && $stable(record_count_reg))
        else $error("sequencer state moved without a transaction");

    a_pause_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pause_ticks_reg <= PAUSE_LEN)
        else $error("pause counter overran");

endmodule

// ----- tb/sweep_checker.sv -----
`timescale 1ns / 1ps
// checker for the sweep sequencer: watches all channels, predicts each result and compares
module sweep_checker
    import gss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_stall,
    input  item_t                 item,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  result_t               result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    mismatches
);

    localparam longint HI32 = 64'sh0000_0000_7FFF_FFFF;
    localparam longint LO32 = -HI32 - 1;

    // register copies
    longint      cfg_top;
    longint      cfg_bottom;
    longint      cfg_speed;
    longint      cfg_step;
    longint      cfg_gp;
    longint      cfg_gd;
    logic [15:0] cfg_div;

    // sequencer state
    logic [2:0]         phase_q;
    longint             tgt_angle;
    longint             tgt_speed;
    longint             enc_hi;
    longint             enc_lo;
    logic [PAUSE_W-1:0] pause_cnt;
    logic [DIV_W-1:0]   div_cnt;
    int unsigned        rec_cnt;

    result_t due_results[$];
    result_t want;
    int      err_cnt;

    function automatic longint clamp32(input longint x);
        if (x > HI32)
            return HI32;
        if (x < LO32)
            return LO32;
        return x;
    endfunction

    // advance the sequencer by one transaction and return what the block must emit
    function automatic result_t sequencer_step(input item_t it);
        longint  enc;
        longint  spd;
        longint  imu;
        longint  err_p;
        longint  err_d;
        result_t r;
        enc = $signed(it.enc_angle);
        spd = $signed(it.enc_speed);
        imu = $signed(it.imu_angle);
        r = '0;
        case (it.cmd)
            CMD_START:
            begin
                if (phase_q == PH_IDLE || phase_q == PH_DONE)
                begin
                    phase_q = PH_INIT;
                    rec_cnt = 0;
                end
            end
            CMD_STOP:
                phase_q = PH_DONE;
            CMD_TICK:
            begin
                case (phase_q)
                    PH_INIT:
                    begin
                        enc_hi = clamp32(cfg_top + (enc - imu));
                        enc_lo = clamp32(cfg_bottom + (enc - imu));
                        tgt_angle = enc;
                        tgt_speed = 0;
                        phase_q = PH_TOP;
                    end
                    PH_TOP:
                    begin
                        if (tgt_angle < enc_hi)
                        begin
                            tgt_angle = clamp32(tgt_angle + cfg_step);
                            tgt_speed = cfg_speed;
                            if (tgt_angle >= enc_hi)
                            begin
                                tgt_angle = enc_hi;
                                pause_cnt = '0;
                                phase_q = PH_PTOP;
                            end
                        end
                        else
                        begin
                            tgt_angle = clamp32(tgt_angle - cfg_step);
                            tgt_speed = -cfg_speed;
                            if (tgt_angle <= enc_hi)
                            begin
                                tgt_angle = enc_hi;
                                pause_cnt = '0;
                                phase_q = PH_PTOP;
                            end
                        end
                    end
                    PH_PTOP, PH_PBOT:
                    begin
                        tgt_speed = 0;
                        pause_cnt = pause_cnt + 1'b1;
                        if (pause_cnt >= PAUSE_LEN)
                        begin
                            if (phase_q == PH_PTOP)
                            begin
                                tgt_speed = -cfg_speed;
                                phase_q = PH_DOWN;
                            end
                            else
                            begin
                                tgt_speed = cfg_speed;
                                phase_q = PH_UP;
                            end
                        end
                    end
                    PH_DOWN:
                    begin
                        tgt_speed = -cfg_speed;
                        tgt_angle = clamp32(tgt_angle - cfg_step);
                        if (tgt_angle <= enc_lo)
                        begin
                            tgt_angle = enc_lo;
                            pause_cnt = '0;
                            phase_q = PH_PBOT;
                        end
                    end
                    PH_UP:
                    begin
                        tgt_speed = cfg_speed;
                        tgt_angle = clamp32(tgt_angle + cfg_step);
                        if (tgt_angle >= enc_hi)
                        begin
                            tgt_angle = enc_hi;
                            phase_q = PH_DONE;
                        end
                    end
                    default:
                        tgt_speed = 0;
                endcase

                if (phase_q != PH_IDLE && phase_q != PH_DONE)
                begin
                    err_p = clamp32(tgt_angle - enc);
                    err_d = clamp32(tgt_speed - spd);
                    // arithmetic shift of the exact product floors toward minus infinity
                    r.torque = 32'(clamp32(((cfg_gp * err_p) >>> FRAC_BITS_DEF)
                                         + ((cfg_gd * err_d) >>> FRAC_BITS_DEF)));
                    if (phase_q == PH_DOWN || phase_q == PH_UP)
                    begin
                        div_cnt = div_cnt + 1'b1;
                        if (div_cnt >= cfg_div)
                        begin
                            div_cnt = '0;
                            if (rec_cnt < MAX_POINTS_DEF)
                            begin
                                r.record_valid = 1'b1;
                                r.record_slot = rec_cnt[SLOT_W-1:0];
                                r.record_enc = it.enc_angle;
                                r.record_imu = it.imu_angle;
                                rec_cnt++;
                            end
                        end
                    end
                end
            end
            default:
                ;
        endcase
        r.phase = phase_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_top = 0;
            cfg_bottom = 0;
            cfg_speed = 0;
            cfg_step = 0;
            cfg_gp = 0;
            cfg_gd = 0;
            cfg_div = 16'd1;
            phase_q = PH_IDLE;
            tgt_angle = 0;
            tgt_speed = 0;
            enc_hi = 0;
            enc_lo = 0;
            pause_cnt = '0;
            div_cnt = '0;
            rec_cnt = 0;
            err_cnt = 0;
            due_results.delete();
            pending <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TOP_IMU_ANGLE:    cfg_top = $signed(cfg_data);
                    REG_BOTTOM_IMU_ANGLE: cfg_bottom = $signed(cfg_data);
                    REG_SWEEP_SPEED:      cfg_speed = cfg_data[30:0];
                    REG_STEP_PER_TICK:    cfg_step = cfg_data[30:0];
                    REG_GAIN_P:           cfg_gp = $signed(cfg_data);
                    REG_GAIN_D:           cfg_gd = $signed(cfg_data);
                    REG_RECORD_DIVIDER:   cfg_div = cfg_data[15:0];
                    default:              ;
                endcase
            end

            if (item_valid && !item_stall)
                due_results.push_back(sequencer_step(item));

            if (result_valid && !result_stall)
            begin
                if (due_results.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("result transaction with nothing outstanding: torque=%0d phase=%0d",
                                 result.torque, result.phase);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.torque !== want.torque || result.phase !== want.phase
                        || result.record_valid !== want.record_valid
                        || result.record_slot !== want.record_slot
                        || result.record_enc !== want.record_enc
                        || result.record_imu !== want.record_imu)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                        begin
                            $display("mismatch expected: torque=%0d phase=%0d rec=%0b slot=%0d enc=%0d imu=%0d",
                                     want.torque, want.phase, want.record_valid,
                                     want.record_slot, want.record_enc, want.record_imu);
                            $display("         actual:   torque=%0d phase=%0d rec=%0b slot=%0d enc=%0d imu=%0d",
                                     result.torque, result.phase, result.record_valid,
                                     result.record_slot, result.record_enc, result.record_imu);
                        end
                    end
                end
            end

            pending <= due_results.size();
            mismatches <= err_cnt;
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// testbench top for the sweep sequencer: clock, reset, stimulus and verdict
module tb;
    import gss_pkg::*;

    localparam int NOISE_ITEMS = 450;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    item_t                 item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    pending;
    int                    mismatches;
    int                    burst_left = 0;
    int                    noise_sent = 0;

    gimbal_sweep_calibration_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    sweep_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .mismatches   (mismatches)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver stall: modes held for random stretches, one of them never stalls
    initial
    begin
        int mode;
        int hold;
        int phase_cnt;
        phase_cnt = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            hold = $urandom_range(20, 200);
            repeat (hold)
            begin
                @(posedge clk);
                phase_cnt++;
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    2:       result_stall <= ($urandom_range(0, 4) < 3);
                    default: result_stall <= (phase_cnt % 8 < 5);
                endcase
            end
        end
    end

    function automatic logic [31:0] near_zero(input int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return near_zero(32'h0004_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        if ($urandom_range(0, 1) == 0)
            return $urandom;
        return near_zero(32'h0002_0000);
    endfunction

    function automatic item_t make_item(input logic [1:0] cmd, input bit wild);
        item_t it;
        it.cmd = cmd;
        if (wild)
        begin
            it.enc_angle = $urandom;
            it.enc_speed = $urandom;
            it.imu_angle = $urandom;
        end
        else
        begin
            it.enc_angle = near_zero(32'h0008_0000);
            it.enc_speed = near_zero(32'h0008_0000);
            it.imu_angle = near_zero(32'h0008_0000);
        end
        return it;
    endfunction

    // drive one transaction and hold it until taken; a burst may end in a random gap
    task automatic send_item(input item_t x);
        item <= x;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 40);
            if ($urandom_range(0, 2) != 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] enc,
                            input logic [31:0] spd, input logic [31:0] imu);
        send_item(item_t'{cmd: cmd, enc_angle: enc, enc_speed: spd, imu_angle: imu});
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // margin after the last result has been checked
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // unused upper bits get random values, the block must ignore them
    task automatic write_regs(input logic [31:0] top_a, input logic [31:0] bot_a,
                              input logic [30:0] speed, input logic [30:0] step,
                              input logic [31:0] gp, input logic [31:0] gd,
                              input logic [15:0] div);
        wait_idle();
        write_reg(REG_TOP_IMU_ANGLE, top_a);
        write_reg(REG_BOTTOM_IMU_ANGLE, bot_a);
        write_reg(REG_SWEEP_SPEED, {1'($urandom), speed});
        write_reg(REG_STEP_PER_TICK, {1'($urandom), step});
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_RECORD_DIVIDER, {16'($urandom), div});
        cfg_write <= 1'b0;
    endtask

    // one complete calibration run: enough ticks to get through both pauses and sweeps
    task automatic run_full(input longint top_a, input longint bot_a,
                            input logic [30:0] step, input logic [15:0] div);
        longint offset;
        longint enc0;
        longint upper;
        longint lower;
        longint stp;
        longint ticks;
        offset = $signed(near_zero(32'h0004_0000));
        enc0 = $signed(near_zero(32'h0004_0000));
        upper = top_a + offset;
        lower = bot_a + offset;
        stp = step;
        ticks = ((upper > enc0) ? upper - enc0 : enc0 - upper) / stp
              + 2 * ((upper > lower) ? upper - lower : lower - upper) / stp
              + 2 * int'(PAUSE_LEN) + 16;
        write_regs(top_a[31:0], bot_a[31:0], 31'($urandom), step, pick_gain(), pick_gain(), div);
        send_item(make_item(CMD_STOP, 1'b1));
        send_item(make_item(CMD_START, 1'b1));
        send_cmd(CMD_TICK, enc0[31:0], $urandom, enc0[31:0] - offset[31:0]);
        repeat (ticks)
            send_item(make_item(CMD_TICK, $urandom_range(0, 3) == 0));
        send_item(make_item(CMD_START, 1'b1));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: limits at +-1.0, extreme gains and speed, divider of zero
        write_regs(32'h0001_0000, 32'hFFFF_0000, 31'h7FFF_FFFF, 31'h0000_4000,
                   32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
        send_cmd(CMD_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_STOP, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_START, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_START, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_UNUSED, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_TICK, 32'h0, 32'h0, 32'h0);
        // ramp to the top limit while the pd terms saturate
        repeat (4)
            send_cmd(CMD_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_cmd(CMD_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_cmd(CMD_STOP, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_TICK, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F);
        // offset so large that both limits saturate high
        send_cmd(CMD_START, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_TICK, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        send_cmd(CMD_TICK, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_START, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_STOP, 32'h0, 32'h0, 32'h0);
        // and saturating low
        send_cmd(CMD_START, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_TICK, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
        send_cmd(CMD_TICK, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_STOP, 32'h0, 32'h0, 32'h0);

        // long sweep with a record every tick overflows the record store
        run_full(64'sd262144, -64'sd262144, 31'd874, 16'd0);
        // bottom above top: the down sweep clamps at once
        run_full(-64'sd65536, 64'sd131072, 31'($urandom_range(32'h1000, 32'h8000)), 16'hFFFF);
        run_full(longint'($urandom_range(0, 32'h8_0000)), -longint'($urandom_range(0, 32'h8_0000)),
                 31'($urandom_range(32'h2000, 32'h2_0000)), 16'($urandom_range(1, 7)));

        // short runs with random settings, broken by stray commands
        while (noise_sent < NOISE_ITEMS)
        begin
            int          n;
            logic [30:0] stp;
            logic [15:0] div;
            logic [1:0]  c;
            case ($urandom_range(0, 4))
                0:       stp = '0;
                1:       stp = 31'($urandom);
                default: stp = 31'($urandom_range(32'h100, 32'h4_0000));
            endcase
            case ($urandom_range(0, 5))
                0:       div = 16'd0;
                1:       div = 16'd1;
                2:       div = 16'hFFFF;
                3:       div = 16'($urandom);
                default: div = 16'($urandom_range(2, 6));
            endcase
            write_regs(pick_angle(), pick_angle(), 31'($urandom), stp, pick_gain(), pick_gain(), div);
            if ($urandom_range(0, 3) != 0)
                send_item(make_item(CMD_STOP, 1'b1));
            send_item(make_item(CMD_START, 1'b1));
            n = $urandom_range(5, 40);
            repeat (n)
            begin
                case ($urandom_range(0, 19))
                    0:       c = CMD_START;
                    1:       c = CMD_STOP;
                    2:       c = CMD_UNUSED;
                    default: c = CMD_TICK;
                endcase
                send_item(make_item(c, $urandom_range(0, 1) == 1));
            end
            noise_sent += n + 2;
        end

        wait_idle();
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- gimbal_sweep_calibration_sequencer.f -----
hw/rtl/gss_pkg.sv
hw/rtl/gimbal_sweep_calibration_sequencer.sv
tb/sweep_checker.sv
tb/tb.sv
